FILE: sv/fault_table_with_latched_trips_assert.svh
// assertion macros shared by the checker
`ifndef FAULT_TABLE_WITH_LATCHED_TRIPS_ASSERT_SVH
`define FAULT_TABLE_WITH_LATCHED_TRIPS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FTLT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fault table check failed");

// next-cycle implication, sampled on clk, off during reset
`define FTLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fault table check failed");

`endif

FILE: sv/fac_pkg.sv
`default_nettype none
package fac_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int TIME_BITS   = 32;
	localparam int HIT_BITS    = 16;
	localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
	localparam int CNT_BITS    = $clog2(TABLE_SLOTS + 1);
	localparam int LEVELS      = 4;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           sev;
		logic [TIME_BITS-1:0] first;
		logic [TIME_BITS-1:0] last;
		logic [HIT_BITS-1:0]  hits;
	} entry_t;

	typedef enum logic [2:0] {
		CMD_REPORT    = 3'd0,
		CMD_EXPIRE    = 3'd1,
		CMD_CONSUME   = 3'd2,
		CMD_CLR_LATCH = 3'd3,
		CMD_CLR_ALL   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_CLEARED = 3'd1,
		STS_NOSRC   = 3'd2,
		STS_BADLVL  = 3'd3,
		STS_DONE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEEK,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	localparam logic [1:0] CFG_DISARM_THR = 2'd0;
	localparam logic [1:0] CFG_BRAKE_THR  = 2'd1;
	localparam logic [1:0] CFG_LATCH_EN   = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

endpackage
`default_nettype wire

FILE: sv/fac_cell.sv
`default_nettype none
module fac_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            clr,
	input  fac_pkg::entry_t      din,
	output fac_pkg::entry_t      dout
);
	import fac_pkg::*;

	logic   valid_q;
	entry_t data_q;

	// valid bit is control state, the rest is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= din;
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule
`default_nettype wire

FILE: sv/fault_table_with_latched_trips.sv
// channel | direction | handshake            | contents
// in      | in        | in_valid / in_stall  | cmd, fault_index, source_valid, severity,
//         |           |                      | fault_active, now_ticks
// out     | out       | out_valid / out_stall| status, worst_*, demands, edge, entry_*,
//         |           |                      | active_total
// cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// the table is a ring of TABLE_SLOTS cells that rotates by one every cycle;
// all entry work happens at the head cell
// valid report: waits in seek until its slot reaches the head cell, then finishes
// expire: one full turn of the ring in the sweep state, then the finish state
// other cmds: finish state; one item in flight, next taken the cycle after the result
// reset clears all valid bits, level counts and latches at once, no clearing pass
// a stalled result holds the block in its finish state until taken
`default_nettype none
module fault_table_with_latched_trips (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    cmd,
	input  wire logic [5:0]                    fault_index,
	input  wire logic                          source_valid,
	input  wire logic [2:0]                    severity,
	input  wire logic                          fault_active,
	input  wire logic [31:0]                   now_ticks,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         status,
	output logic                               worst_valid,
	output logic [1:0]                         worst_severity,
	output logic                               disarm_demand,
	output logic                               brake_demand,
	output logic                               disarm_edge,
	output logic [15:0]                        entry_hits,
	output logic [31:0]                        entry_first_seen,
	output logic [6:0]                         active_total,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import fac_pkg::*;

	// configuration registers
	logic [1:0]  dis_thr_q;
	logic [1:0]  brk_thr_q;
	logic        latch_en_q;
	logic [31:0] timeout_q;

	// control
	state_t               state_q, state_d;
	logic [SLOT_BITS-1:0] head_q;
	logic [SLOT_BITS-1:0] sweep_q;

	// captured item
	logic [SLOT_BITS-1:0] slot_q;
	logic [1:0]           sev_q;
	logic                 act_q;
	logic [TIME_BITS-1:0] now_q;

	// result under construction
	status_t              status_q;
	logic                 edge_q;
	logic [HIT_BITS-1:0]  hits_q;
	logic [TIME_BITS-1:0] first_q;

	// summary state
	logic [CNT_BITS-1:0] lvl_cnt_q [LEVELS];
	logic                dis_lat_q;
	logic                brk_lat_q;
	logic                edge_seen_q;

	// output register
	logic        out_valid_q;
	status_t     out_status_q;
	logic        out_wv_q;
	logic [1:0]  out_ws_q;
	logic        out_dis_q;
	logic        out_brk_q;
	logic        out_edge_q;
	logic [15:0] out_hits_q;
	logic [31:0] out_first_q;
	logic [6:0]  out_total_q;

	// ring of cells, cell 0 is the head
	entry_t ring [TABLE_SLOTS];
	entry_t head_out;
	logic   clr_all;

	// head strobes
	logic       dec_en, inc_en;
	logic [1:0] dec_lvl, inc_lvl;
	logic       dis_set, brk_set, cap_en, fin_load;
	logic       in_acc, out_free;

	// summary views
	logic                any_dis, any_brk, cur_dis, fin_wv;
	logic [1:0]          fin_ws;
	logic [CNT_BITS+1:0] fin_total;
	logic [TIME_BITS-1:0] age;
	logic [SLOT_BITS-1:0] in_slot;

	function automatic logic any_at_or_below(input logic [3:0] nz, input logic [1:0] thr);
		logic hit;
		hit = 1'b0;
		for (int l = 0; l < LEVELS; l++) begin
			if (2'(l) <= thr && nz[l]) hit = 1'b1;
		end
		return hit;
	endfunction

	genvar k;
	generate
		for (k = 0; k < TABLE_SLOTS; k++) begin : g_cell
			if (k == TABLE_SLOTS - 1) begin : g_tail
				fac_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.clr    (clr_all),
					.din    (head_out),
					.dout   (ring[k])
				);
			end else begin : g_body
				fac_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.clr    (clr_all),
					.din    (ring[k+1]),
					.dout   (ring[k])
				);
			end
		end
	endgenerate

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign clr_all   = in_acc && (cmd == CMD_CLR_ALL);
	assign in_slot   = SLOT_BITS'(32'(fault_index) % TABLE_SLOTS);
	assign age       = now_q - ring[0].last;

	// nonzero level flags feed worst level and demands
	logic [3:0] lvl_nz;
	always_comb begin
		for (int l = 0; l < LEVELS; l++) lvl_nz[l] = (lvl_cnt_q[l] != '0);
		any_dis = any_at_or_below(lvl_nz, dis_thr_q);
		any_brk = any_at_or_below(lvl_nz, brk_thr_q);
		cur_dis = latch_en_q ? (any_dis || dis_lat_q) : any_dis;
		fin_wv  = |lvl_nz;
		fin_ws  = lvl_nz[0] ? 2'd0 : lvl_nz[1] ? 2'd1 : lvl_nz[2] ? 2'd2 : lvl_nz[3] ? 2'd3 : 2'd0;
		fin_total = '0;
		for (int l = 0; l < LEVELS; l++) fin_total = fin_total + (CNT_BITS+2)'(lvl_cnt_q[l]);
	end

	// next state and head processing
	always_comb begin
		state_d  = state_q;
		head_out = ring[0];
		dec_en   = 1'b0;
		dec_lvl  = ring[0].sev;
		inc_en   = 1'b0;
		inc_lvl  = sev_q;
		dis_set  = 1'b0;
		brk_set  = 1'b0;
		cap_en   = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_REPORT && source_valid && severity <= 3'd3) begin
						state_d = ST_SEEK;
					end else if (cmd == CMD_EXPIRE) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SEEK: begin
				if (head_q == slot_q) begin
					state_d = ST_FINISH;
					if (!act_q) begin
						// clear, an empty slot stays empty
						head_out.valid = 1'b0;
						dec_en         = ring[0].valid;
					end else begin
						if (!ring[0].valid) begin
							head_out.first = now_q;
							head_out.hits  = HIT_BITS'(1);
						end else begin
							dec_en = 1'b1;
							if (ring[0].hits != '1) head_out.hits = ring[0].hits + HIT_BITS'(1);
						end
						head_out.valid = 1'b1;
						head_out.sev   = sev_q;
						head_out.last  = now_q;
						inc_en         = 1'b1;
						dis_set        = latch_en_q && (sev_q <= dis_thr_q);
						brk_set        = latch_en_q && (sev_q <= brk_thr_q);
						cap_en         = 1'b1;
					end
				end
			end
			ST_SWEEP: begin
				// wrapping age against the timeout
				if (ring[0].valid && (64'(age) > 64'(timeout_q))) begin
					head_out.valid = 1'b0;
					dec_en         = 1'b1;
				end
				if (sweep_q == SLOT_BITS'(TABLE_SLOTS - 1)) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			sweep_q     <= '0;
			dis_lat_q   <= 1'b0;
			brk_lat_q   <= 1'b0;
			edge_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
			dis_thr_q   <= 2'd0;
			brk_thr_q   <= 2'd0;
			latch_en_q  <= 1'b1;
			timeout_q   <= 32'd1000;
			for (int l = 0; l < LEVELS; l++) lvl_cnt_q[l] <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= (head_q == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : head_q + SLOT_BITS'(1);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DISARM_THR: dis_thr_q  <= cfg_data[1:0];
					CFG_BRAKE_THR:  brk_thr_q  <= cfg_data[1:0];
					CFG_LATCH_EN:   latch_en_q <= cfg_data[0];
					CFG_TIMEOUT:    timeout_q  <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_SWEEP) sweep_q <= sweep_q + SLOT_BITS'(1);
			else sweep_q <= '0;

			// level counts: at most one drop and one add per cycle
			for (int l = 0; l < LEVELS; l++) begin
				if (clr_all) begin
					lvl_cnt_q[l] <= '0;
				end else begin
					lvl_cnt_q[l] <= lvl_cnt_q[l]
						+ CNT_BITS'(inc_en && inc_lvl == 2'(l))
						- CNT_BITS'(dec_en && dec_lvl == 2'(l));
				end
			end

			if (dis_set) dis_lat_q <= 1'b1;
			if (brk_set) brk_lat_q <= 1'b1;

			if (in_acc && cmd == CMD_CONSUME) begin
				if (latch_en_q && any_dis) dis_lat_q <= 1'b1;
				edge_seen_q <= cur_dis;
			end
			if (in_acc && cmd == CMD_CLR_LATCH) begin
				dis_lat_q   <= 1'b0;
				brk_lat_q   <= 1'b0;
				edge_seen_q <= 1'b0;
			end

			if (fin_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q  <= in_slot;
			sev_q   <= severity[1:0];
			act_q   <= fault_active;
			now_q   <= TIME_BITS'(now_ticks);
			edge_q  <= (cmd == CMD_CONSUME) && cur_dis && !edge_seen_q;
			hits_q  <= '0;
			first_q <= '0;
			if (cmd == CMD_REPORT) begin
				if (!source_valid) status_q <= STS_NOSRC;
				else if (severity > 3'd3) status_q <= STS_BADLVL;
				else if (fault_active) status_q <= STS_OK;
				else status_q <= STS_CLEARED;
			end else begin
				status_q <= STS_DONE;
			end
		end
		if (cap_en) begin
			hits_q  <= head_out.hits;
			first_q <= head_out.first;
		end
		if (fin_load) begin
			out_status_q <= status_q;
			out_wv_q     <= fin_wv;
			out_ws_q     <= fin_ws;
			out_dis_q    <= dis_lat_q || any_dis;
			out_brk_q    <= brk_lat_q || any_brk;
			out_edge_q   <= edge_q;
			out_hits_q   <= 16'(hits_q);
			out_first_q  <= 32'(first_q);
			out_total_q  <= 7'(fin_total);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign worst_valid      = out_wv_q;
	assign worst_severity   = out_ws_q;
	assign disarm_demand    = out_dis_q;
	assign brake_demand     = out_brk_q;
	assign disarm_edge      = out_edge_q;
	assign entry_hits       = out_hits_q;
	assign entry_first_seen = out_first_q;
	assign active_total     = out_total_q;

endmodule
`default_nettype wire

FILE: sv/fac_checker.sv
`default_nettype none
`include "fault_table_with_latched_trips_assert.svh"
module fac_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  cmd,
	input wire logic [5:0]  fault_index,
	input wire logic        source_valid,
	input wire logic [2:0]  severity,
	input wire logic        fault_active,
	input wire logic [31:0] now_ticks,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic        worst_valid,
	input wire logic [1:0]  worst_severity,
	input wire logic        disarm_demand,
	input wire logic        brake_demand,
	input wire logic        disarm_edge,
	input wire logic [15:0] entry_hits,
	input wire logic [31:0] entry_first_seen,
	input wire logic [6:0]  active_total,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [31:0] cfg_data
);
	import fac_pkg::*;

	`FTLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`FTLT_ASSERT_NOW(a_worst_total, out_valid, worst_valid == (active_total != 7'd0))
	`FTLT_ASSERT_NOW(a_entry_zero, out_valid && status != STS_OK,
		entry_hits == 16'd0 && entry_first_seen == 32'd0)
	`FTLT_ASSERT_NOW(a_accept_active, out_valid && status == STS_OK,
		worst_valid && entry_hits != 16'd0)
	`FTLT_ASSERT_NOW(a_edge_demand, out_valid && disarm_edge, disarm_demand)

endmodule

bind fault_table_with_latched_trips fac_checker u_fac_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
	import fac_pkg::*;

	// one result item of the fault table
	typedef struct packed {
		logic [2:0]  status;
		logic        worst_valid;
		logic [1:0]  worst_severity;
		logic        disarm_demand;
		logic        brake_demand;
		logic        disarm_edge;
		logic [15:0] entry_hits;
		logic [31:0] entry_first_seen;
		logic [6:0]  active_total;
	} fault_reply_t;

	// scoreboard: private model of the table plus the queue of expected replies
	class fault_scoreboard;
		bit [1:0]  disarm_thr;
		bit [1:0]  brake_thr;
		bit        latch_en;
		bit [31:0] timeout;
		bit        live [TABLE_SLOTS];
		bit [1:0]  lvl [TABLE_SLOTS];
		bit [31:0] first_seen [TABLE_SLOTS];
		bit [31:0] last_seen [TABLE_SLOTS];
		bit [15:0] hit_count [TABLE_SLOTS];
		int        level_count [LEVELS];
		bit        disarm_lat, brake_lat, edge_taken;
		fault_reply_t pending [$];
		int        errors;
		int        replies_seen;
		int        live_peak;

		function new();
			disarm_thr = 0;
			brake_thr = 0;
			latch_en = 1;
			timeout = 1000;
			foreach (live[i]) live[i] = 0;
			foreach (level_count[i]) level_count[i] = 0;
			disarm_lat = 0;
			brake_lat = 0;
			edge_taken = 0;
			errors = 0;
			replies_seen = 0;
			live_peak = 0;
		endfunction

		function void write_reg(bit [1:0] idx, bit [31:0] data);
			case (idx)
				CFG_DISARM_THR: disarm_thr = data[1:0];
				CFG_BRAKE_THR:  brake_thr = data[1:0];
				CFG_LATCH_EN:   latch_en = data[0];
				CFG_TIMEOUT:    timeout = data;
				default: ;
			endcase
		endfunction

		function void drop(int s);
			if (live[s]) begin
				live[s] = 0;
				level_count[lvl[s]]--;
			end
		endfunction

		function bit any_at_or_below(bit [1:0] limit);
			for (int l = 0; l <= limit; l++)
				if (level_count[l] != 0) return 1;
			return 0;
		endfunction

		// an input item was accepted: advance the model and queue its reply
		function void note_item(bit [2:0] c, bit [5:0] idx, bit src, bit [2:0] sev,
				bit act, bit [31:0] now);
			fault_reply_t r;
			bit cur;
			int total;
			r = '0;
			r.status = STS_DONE;
			case (c)
				CMD_REPORT: begin
					if (!src) r.status = STS_NOSRC;
					else if (sev > 3) r.status = STS_BADLVL;
					else if (!act) begin
						drop(idx);
						r.status = STS_CLEARED;
					end else begin
						if (!live[idx]) begin
							live[idx] = 1;
							first_seen[idx] = now;
							hit_count[idx] = 1;
						end else begin
							level_count[lvl[idx]]--;
							if (hit_count[idx] != 16'hffff) hit_count[idx]++;
						end
						lvl[idx] = sev[1:0];
						level_count[sev[1:0]]++;
						last_seen[idx] = now;
						if (latch_en) begin
							if (sev[1:0] <= disarm_thr) disarm_lat = 1;
							if (sev[1:0] <= brake_thr) brake_lat = 1;
						end
						r.entry_hits = hit_count[idx];
						r.entry_first_seen = first_seen[idx];
						r.status = STS_OK;
					end
				end
				CMD_EXPIRE: begin
					// wrapping age, compared unsigned
					for (int i = 0; i < TABLE_SLOTS; i++)
						if (live[i] && (32'(now - last_seen[i]) > timeout)) drop(i);
				end
				CMD_CONSUME: begin
					cur = any_at_or_below(disarm_thr);
					if (latch_en) begin
						if (cur) disarm_lat = 1;
						cur = disarm_lat;
					end
					if (cur && !edge_taken) begin
						edge_taken = 1;
						r.disarm_edge = 1;
					end else if (!cur) edge_taken = 0;
				end
				CMD_CLR_LATCH: begin
					disarm_lat = 0;
					brake_lat = 0;
					edge_taken = 0;
				end
				CMD_CLR_ALL: for (int i = 0; i < TABLE_SLOTS; i++) drop(i);
				default: ;
			endcase
			total = 0;
			for (int l = LEVELS - 1; l >= 0; l--) begin
				total += level_count[l];
				if (level_count[l] != 0) begin
					r.worst_valid = 1;
					r.worst_severity = l[1:0];
				end
			end
			r.disarm_demand = disarm_lat || any_at_or_below(disarm_thr);
			r.brake_demand = brake_lat || any_at_or_below(brake_thr);
			r.active_total = total[6:0];
			if (total > live_peak) live_peak = total;
			pending.push_back(r);
		endfunction

		function void check_reply(fault_reply_t got);
			fault_reply_t e;
			replies_seen++;
			if (pending.size() == 0) begin
				$display("%0t: reply with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status)
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
			if (got.worst_valid !== e.worst_valid)
				$display("%0t: worst_valid expected %0d actual %0d", $time,
					e.worst_valid, got.worst_valid);
			if (got.worst_severity !== e.worst_severity)
				$display("%0t: worst_severity expected %0d actual %0d", $time,
					e.worst_severity, got.worst_severity);
			if (got.disarm_demand !== e.disarm_demand)
				$display("%0t: disarm_demand expected %0d actual %0d", $time,
					e.disarm_demand, got.disarm_demand);
			if (got.brake_demand !== e.brake_demand)
				$display("%0t: brake_demand expected %0d actual %0d", $time,
					e.brake_demand, got.brake_demand);
			if (got.disarm_edge !== e.disarm_edge)
				$display("%0t: disarm_edge expected %0d actual %0d", $time,
					e.disarm_edge, got.disarm_edge);
			if (got.entry_hits !== e.entry_hits)
				$display("%0t: entry_hits expected %0d actual %0d", $time,
					e.entry_hits, got.entry_hits);
			if (got.entry_first_seen !== e.entry_first_seen)
				$display("%0t: entry_first_seen expected %0h actual %0h", $time,
					e.entry_first_seen, got.entry_first_seen);
			if (got.active_total !== e.active_total)
				$display("%0t: active_total expected %0d actual %0d", $time,
					e.active_total, got.active_total);
			if (got !== e) errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [5:0]  fault_index;
	logic        source_valid;
	logic [2:0]  severity;
	logic        fault_active;
	logic [31:0] now_ticks;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic        worst_valid;
	logic [1:0]  worst_severity;
	logic        disarm_demand;
	logic        brake_demand;
	logic        disarm_edge;
	logic [15:0] entry_hits;
	logic [31:0] entry_first_seen;
	logic [6:0]  active_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	fault_table_with_latched_trips u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .fault_index(fault_index), .source_valid(source_valid),
		.severity(severity), .fault_active(fault_active), .now_ticks(now_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .worst_valid(worst_valid), .worst_severity(worst_severity),
		.disarm_demand(disarm_demand), .brake_demand(brake_demand),
		.disarm_edge(disarm_edge), .entry_hits(entry_hits),
		.entry_first_seen(entry_first_seen), .active_total(active_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fault_scoreboard sb;
	int        quiet_cycles;
	bit [31:0] clock_ticks;   // running time base for reports
	int        items_sent;

	// worst case: a full ring walk plus the random input gap and output stall around it, many times over
	localparam int WATCHDOG_LIMIT = 2000;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stall per item, check at the accepting edge
	initial begin
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_reply({status, worst_valid, worst_severity, disarm_demand,
				brake_demand, disarm_edge, entry_hits, entry_first_seen, active_total});
		end
	end

	// register write while the block is idle
	task automatic write_reg(bit [1:0] idx, bit [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// wait until every expected reply has come
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid stays up after an accept until the next item or an idle stretch
	task automatic send_item(bit [2:0] c, bit [5:0] idx, bit src, bit [2:0] sev,
			bit act, bit [31:0] now, bit with_gap);
		int gap;
		gap = with_gap ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		fault_index <= idx;
		source_valid <= src;
		severity <= sev;
		fault_active <= act;
		now_ticks <= now;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(c, idx, src, sev, act, now);
		items_sent++;
	endtask

	// random item, mostly well-formed reports with a time base that creeps forward
	task automatic send_random(bit with_gap, bit [5:0] slot_span);
		int pick;
		bit [2:0] c;
		bit [2:0] sev;
		pick = $urandom_range(0, 99);
		clock_ticks += $urandom_range(0, 40);
		if (pick < 60) c = CMD_REPORT;
		else if (pick < 72) c = CMD_EXPIRE;
		else if (pick < 84) c = CMD_CONSUME;
		else if (pick < 91) c = CMD_CLR_LATCH;
		else if (pick < 94) c = CMD_CLR_ALL;
		else c = 3'($urandom_range(5, 7));
		sev = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
		send_item(c, 6'($urandom_range(0, slot_span)),
			$urandom_range(0, 11) != 0, sev, $urandom_range(0, 4) != 0,
			($urandom_range(0, 19) == 0) ? $urandom : clock_ticks, with_gap);
	endtask

	initial begin
		bit gaps;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_REPORT;
		fault_index = '0;
		source_valid = 1'b0;
		severity = '0;
		fault_active = 1'b0;
		now_ticks = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DISARM_THR;
		cfg_data = '0;
		quiet_cycles = 0;
		clock_ticks = 32'd100;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejections, create, refresh, clear, extremes of time and index
		send_item(CMD_REPORT, 6'd0, 1'b0, 3'd7, 1'b1, 32'd0, 1);       // no source wins
		send_item(CMD_REPORT, 6'd0, 1'b1, 3'd4, 1'b1, 32'd0, 1);       // bad level
		send_item(CMD_REPORT, 6'd63, 1'b1, 3'd3, 0, 32'd5, 1);         // clear empty slot
		send_item(CMD_REPORT, 6'd63, 1'b1, 3'd3, 1'b1, 32'hffff_fff0, 1);
		send_item(CMD_REPORT, 6'd63, 1'b1, 3'd1, 1'b1, 32'hffff_ffff, 1); // refresh
		send_item(CMD_REPORT, 6'd0, 1'b1, 3'd0, 1'b1, 32'd10, 1);      // sets latches
		send_item(CMD_CONSUME, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);         // edge
		send_item(CMD_CONSUME, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);         // no edge again while the demand holds
		send_item(CMD_EXPIRE, 6'd0, 1'b0, 3'd0, 0, 32'd500, 1);        // wrapped age small
		send_item(CMD_EXPIRE, 6'd0, 1'b0, 3'd0, 0, 32'd2000, 1);       // all expire
		send_item(CMD_CONSUME, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);         // latched demand
		send_item(CMD_CLR_LATCH, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);
		send_item(CMD_CONSUME, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);         // demand 0
		send_item(CMD_REPORT, 6'd5, 1'b1, 3'd2, 1'b1, 32'd20, 1);
		send_item(CMD_REPORT, 6'd5, 1'b1, 3'd2, 0, 32'd21, 1);         // clear live slot
		send_item(CMD_REPORT, 6'd9, 1'b1, 3'd3, 1'b1, 32'd22, 1);
		send_item(CMD_CLR_ALL, 6'd0, 1'b0, 3'd0, 0, 32'd0, 1);
		send_item(3'd5, 6'd0, 1'b1, 3'd0, 1'b1, 32'd0, 1);             // unused codes
		send_item(3'd7, 6'd63, 1'b1, 3'd7, 1'b1, 32'hffff_ffff, 1);
		drain();

		// repeated refresh of one slot, back to back
		write_reg(CFG_TIMEOUT, 32'hffff_ffff);
		for (int i = 0; i < 2; i++) send_item(CMD_REPORT, 6'd1, 1'b1, 3'd2, 1'b1, 32'd7, 0);
		drain();

		// random phases over several register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_DISARM_THR, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hffff_ffff
				: $urandom);
			write_reg(CFG_BRAKE_THR, (ph == 0) ? 32'd3 : (ph == 1) ? 32'd0 : $urandom);
			write_reg(CFG_LATCH_EN, (ph % 3 == 2) ? 32'hffff_fffe : $urandom);
			write_reg(CFG_TIMEOUT, (ph == 2) ? 32'd0 : (ph == 3) ? 32'hffff_ffff
				: (ph == 4) ? $urandom : $urandom_range(50, 2000));
			for (int n = 0; n < 190; n++) begin
				gaps = (ph % 2 == 1) || (n % 50 < 25);
				send_random(gaps, (ph == 5) ? 6'd63 : 6'($urandom_range(7, 63)));
				if (n == 95 && ph == 4) drain();   // sender holds off until all replies are in
			end
			drain();
		end

		drain();
		repeat (80) @(posedge clk);
		$display("ran %0d items, %0d replies checked, at most %0d live entries",
			items_sent, sb.replies_seen, sb.live_peak);
		$display("covered reports, expiry, consume edges, latch and table clears");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/fac_pkg.sv
sv/fac_cell.sv
sv/fault_table_with_latched_trips.sv
sv/fac_checker.sv
bench/testbench.sv
